// ===== design/psg_pkg.sv =====
package psg_pkg;

  localparam int unsigned SrcW    = 16;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned WinW    = 31;
  localparam int unsigned SumW    = 64;
  localparam int unsigned StatusW = 3;

  localparam logic [WinW-1:0] WindowReset = 31'd4096;

  typedef enum logic [StatusW-1:0] {
    ST_NEW     = 3'd0,
    ST_INORDER = 3'd1,
    ST_GAP     = 3'd2,
    ST_DUP     = 3'd3,
    ST_REORDER = 3'd4,
    ST_RESYNC  = 3'd5,
    ST_FULL    = 3'd6
  } status_e;

  // Verdict for one word, passed from the classifier to the update stage.
  typedef struct packed {
    status_e         status;
    logic [WinW-1:0] missed;
    logic            wr_seq;     // store the new sequence in the matched row
    logic            new_entry;  // append a row for an unknown source
  } cls_t;

endpackage

// ===== design/psg_if.sv =====
interface psg_in_if;
  logic                       valid;
  logic                       ready;
  logic [psg_pkg::SrcW-1:0]   src_id;
  logic [psg_pkg::SeqW-1:0]   sequence_req;

  modport source (output valid, src_id, sequence_req, input ready);
  modport sink   (input valid, src_id, sequence_req, output ready);
endinterface

interface psg_out_if;
  logic                       valid;
  logic                       ready;
  psg_pkg::status_e           status;
  logic [psg_pkg::WinW-1:0]   missed_count;
  logic [psg_pkg::SumW-1:0]   gap_total;

  modport source (output valid, status, missed_count, gap_total, input ready);
  modport sink   (input valid, status, missed_count, gap_total, output ready);
endinterface

// ===== design/psg_mem.sv =====
module psg_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 48,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/psg_classify.sv =====
module psg_classify (
  input  logic                      found_i,
  input  logic                      full_i,
  input  logic [psg_pkg::SeqW-1:0]  seq_i,
  input  logic [psg_pkg::SeqW-1:0]  last_i,
  input  logic [psg_pkg::WinW-1:0]  window_i,
  output psg_pkg::cls_t             cls_o
);
  import psg_pkg::*;

  logic [SeqW-1:0] diff;
  logic [SeqW-1:0] back;

  assign diff = seq_i - last_i;
  // Backward distance; for the most negative difference this is 2^31, above any window.
  assign back = SeqW'(0) - diff;

  always_comb begin
    cls_o           = '0;
    cls_o.status    = ST_REORDER;
    if (!found_i) begin
      if (full_i) begin
        cls_o.status    = ST_FULL;
      end else begin
        cls_o.status    = ST_NEW;
        cls_o.new_entry = 1'b1;
      end
    end else if (diff == SeqW'(1)) begin
      cls_o.status = ST_INORDER;
      cls_o.wr_seq = 1'b1;
    end else if (!diff[SeqW-1] && diff != '0) begin
      cls_o.status = ST_GAP;
      cls_o.missed = WinW'(diff - SeqW'(1));
      cls_o.wr_seq = 1'b1;
    end else if (diff == '0) begin
      cls_o.status = ST_DUP;
    end else if (back > {1'b0, window_i}) begin
      cls_o.status = ST_RESYNC;
      cls_o.wr_seq = 1'b1;
    end
  end

endmodule

// ===== design/per_source_sequence_gap_tracker.sv =====
// Flow: idle, table search (skipped with an empty table), calculate, update;
// the search reads one table row per cycle, and the update waits while an
// untaken result holds the output register. A new word is taken in idle,
// also while a finished result still waits in the output register.
// Reset: source count, gap total and control clear, window returns to 4096;
// table rows are not cleared and need no clearing pass.
module per_source_sequence_gap_tracker #(
  parameter int unsigned TABLE_ENTRIES  = 64,
  parameter int unsigned SOURCE_ID_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [psg_pkg::WinW-1:0]  cfg_wdata_i,
  psg_in_if.sink                    in_i,
  psg_out_if.source                 out_o
);
  import psg_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KeyW = SOURCE_ID_BITS;
  localparam int unsigned RowW = KeyW + SeqW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_CALC = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e          state_q;
  logic [WinW-1:0] window_q;
  logic [CntW-1:0] used_q;
  logic [SumW-1:0] sum_q;
  logic [SumW-1:0] sum_d;
  logic [KeyW-1:0] key_q;
  logic [SeqW-1:0] seq_q;
  logic [SeqW-1:0] last_q;
  logic            found_q;
  logic [IdxW-1:0] slot_q;
  logic [CntW-1:0] issue_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  cls_t            cls_d;
  cls_t            cls_q;

  logic            out_vld_q;
  status_e         out_status_q;
  logic [WinW-1:0] out_missed_q;
  logic [SumW-1:0] out_total_q;

  logic [31:0]     src_ext;
  logic [KeyW-1:0] in_key;
  logic            full;
  logic            rd_en;
  logic            mem_we;
  logic [IdxW-1:0] waddr;
  logic [RowW-1:0] rdata;
  logic            row_hit;
  logic            row_last;
  logic            upd_go;

  assign src_ext  = 32'(in_i.src_id);
  assign in_key   = src_ext[KeyW-1:0];
  assign full     = (used_q == CntW'(TABLE_ENTRIES));
  assign rd_en    = (state_q == S_SCAN) && (issue_q < used_q);
  assign row_hit  = rd_vld_q && (rdata[RowW-1:SeqW] == key_q);
  assign row_last = rd_vld_q && (CntW'(rd_idx_q) == used_q - CntW'(1));
  assign upd_go   = (state_q == S_UPD) && (!out_vld_q || out_o.ready);
  assign mem_we   = upd_go && (cls_q.wr_seq || cls_q.new_entry);
  assign waddr    = cls_q.new_entry ? used_q[IdxW-1:0] : slot_q;
  assign sum_d    = sum_q + SumW'(cls_q.missed);

  psg_mem #(
    .Depth (TABLE_ENTRIES),
    .Width (RowW),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i ({key_q, seq_q}),
    .re_i    (rd_en),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  psg_classify u_classify (
    .found_i  (found_q),
    .full_i   (full),
    .seq_i    (seq_q),
    .last_i   (last_q),
    .window_i (window_q),
    .cls_o    (cls_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      sum_q    <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (rd_en) begin
        issue_q <= issue_q + CntW'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            issue_q <= '0;
            found_q <= 1'b0;
            state_q <= (used_q == '0) ? S_CALC : S_SCAN;
          end
        end
        S_SCAN: begin
          // Stop at the first matching row or after the last valid row.
          if (row_hit) begin
            found_q <= 1'b1;
            state_q <= S_CALC;
          end else if (row_last) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            sum_q <= sum_d;
            if (cls_q.new_entry) begin
              used_q <= used_q + CntW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      key_q <= in_key;
      seq_q <= in_i.sequence_req;
    end
    if (state_q == S_SCAN && row_hit) begin
      slot_q <= rd_idx_q;
      last_q <= rdata[SeqW-1:0];
    end
    if (rd_en) begin
      rd_idx_q <= issue_q[IdxW-1:0];
    end
    if (state_q == S_CALC) begin
      cls_q <= cls_d;
    end
  end

  // Output register: hold the word until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (upd_go) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      out_status_q <= cls_q.status;
      out_missed_q <= cls_q.missed;
      out_total_q  <= sum_d;
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_status_q;
  assign out_o.missed_count = out_missed_q;
  assign out_o.gap_total    = out_total_q;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(TABLE_ENTRIES))
    else $error("source count above table size");

  a_write_in_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_UPD))
    else $error("table write outside update");

  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_go |=> $stable(sum_q))
    else $error("gap total moved without an update");

  a_missed_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q != ST_GAP) |-> (out_missed_q == '0))
    else $error("missed count set without a gap");
`endif

endmodule
